/* hdl/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared widths, limits, register map and sequencer step codes for the
// z-axis passivity controller.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int DATA_W      = 48;   // signed fixed-point word
  localparam int COEF_W      = 47;   // unsigned coefficients
  localparam int IN_TDATA_W  = 144;  // velocity, force, received energy
  localparam int IN_TUSER_W  = 2;    // velocity_sent, force_valid
  localparam int OUT_TDATA_W = 192;  // 191 bits of fields, one pad bit
  localparam int OUT_TUSER_W = 1;    // force_out_valid
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;

  // multiplier: 48-bit magnitude times a 16-bit slice per cycle
  localparam int MUL_CHUNK_W = 16;
  localparam int MUL_STEPS   = 3;
  localparam int ACC_W       = 2 * DATA_W;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]        COEF_MAX = {COEF_W{1'b1}};

  // register index, taken from paddr[5:3]
  localparam logic [2:0] REG_TDPA_EN  = 3'd0;
  localparam logic [2:0] REG_ISS_EN   = 3'd1;
  localparam logic [2:0] REG_ISS_GAIN = 3'd2;
  localparam logic [2:0] REG_ISS_TAU  = 3'd3;
  localparam logic [2:0] REG_PERIOD   = 3'd4;
  localparam logic [2:0] REG_RATE     = 3'd5;
  localparam logic [2:0] REG_VEL_THR  = 3'd6;
  localparam logic [2:0] REG_OUT_DAMP = 3'd7;

  // multiply steps run by the sequencer
  typedef enum logic [2:0] {
    STP_VCORR,   // force_rate * gain, velocity correction
    STP_POWER,   // v * f
    STP_ENERGY,  // power * T
    STP_TDPA,    // damping * v
    STP_RATE,    // (f - prev) * sample_rate
    STP_TAU,     // force_rate * tau
    STP_OUTD     // v * output_damping
  } step_t;

  // clamp a 49-bit sum to the 48-bit signed range
  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [DATA_W:0] x);
    if (x[DATA_W] != x[DATA_W-1]) return x[DATA_W] ? Q_MIN : Q_MAX;
    return x[DATA_W-1:0];
  endfunction

endpackage

/* hdl/passivity_controller_damping.sv */
// ----------------------------------------------------------------------------
// passivity_controller_damping
// Master-side z-axis time-domain passivity controller, one request per tick.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* stream: one request per control tick (velocity, force message,
//    slave energy). in_tready is high only while the sequencer is idle.
//  - out_* stream: exactly one result per request, held in an output
//    register; the next request is taken while a result waits there.
//  - APB port: 8 registers at byte address 8*i, 64-bit data, pready tied
//    high. Write only while no request is in flight.
//  - Datapath: one shared 48x16 multiplier runs every product as operand
//    load, 16-bit partial products and write-back. Without a force message
//    at most the velocity correction runs. With one, the damping divide
//    runs on the bit-serial restoring divider, numerator 48+3*FRAC_BITS
//    bits (120 at Q24.24), if passivity fails and the period is nonzero.
//  - Reset clears the energy state, the force history and the output
//    valid flag, and loads the default register values.
//  - While the output register is full and out_tready is low, a finished
//    result waits in the done state; no further request is taken meanwhile.
// ----------------------------------------------------------------------------
module passivity_controller_damping #(
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // velocity_z [47:0], force_z [95:48], received_energy [143:96]
  input  logic [pcd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // velocity_sent [0], force_valid [1]
  input  logic [pcd_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // velocity_out [47:0], energy_out [95:48], force_out [143:96],
  // damping [190:144], zero [191]
  output logic [pcd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // force_out_valid [0]
  output logic [pcd_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcd_pkg::CFG_AW-1:0]        paddr,
  input  logic [pcd_pkg::CFG_DW-1:0]        pwdata,
  output logic [pcd_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);
  import pcd_pkg::*;

  // divider numerator: 48-bit energy excess shifted up by 3*FRAC_BITS
  localparam int NUM_W   = DATA_W + 3 * FRAC_BITS;
  localparam int DCNT_W  = $clog2(NUM_W);

  // register defaults, scaled to the fraction width
  localparam logic [63:0] ONE_Q      = 64'd1 << FRAC_BITS;
  localparam logic [63:0] RST_GAIN   = (64'd214542 << FRAC_BITS) >> 24;
  localparam logic [63:0] RST_TAU    = ONE_Q / 200;
  localparam logic [63:0] RST_PERIOD = ONE_Q / 1000;
  localparam logic [63:0] RST_RATE   = ONE_Q * 1000;
  localparam logic [63:0] RST_THR    = ONE_Q / 1000;
  localparam logic [63:0] RST_ODAMP  = (ONE_Q * 15) / 100;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a request
    ST_ISSUE,  // load multiplier operands for step_r
    ST_MUL,    // partial products
    ST_WB,     // round, saturate, write back
    ST_CHECK,  // passivity condition
    ST_DIV,    // restoring divide, one bit per cycle
    ST_DFIN,   // clamp quotient
    ST_DONE    // hand result to the output register
  } state_t;

  // ---------------- configuration ----------------
  logic              tdpa_en_r, iss_en_r;
  logic [COEF_W-1:0] iss_gain_r, iss_tau_r, period_r, rate_r, vel_thr_r, out_damp_r;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[5:3])
      REG_TDPA_EN:  prdata = {{(CFG_DW-1){1'b0}}, tdpa_en_r};
      REG_ISS_EN:   prdata = {{(CFG_DW-1){1'b0}}, iss_en_r};
      REG_ISS_GAIN: prdata = {{(CFG_DW-COEF_W){1'b0}}, iss_gain_r};
      REG_ISS_TAU:  prdata = {{(CFG_DW-COEF_W){1'b0}}, iss_tau_r};
      REG_PERIOD:   prdata = {{(CFG_DW-COEF_W){1'b0}}, period_r};
      REG_RATE:     prdata = {{(CFG_DW-COEF_W){1'b0}}, rate_r};
      REG_VEL_THR:  prdata = {{(CFG_DW-COEF_W){1'b0}}, vel_thr_r};
      REG_OUT_DAMP: prdata = {{(CFG_DW-COEF_W){1'b0}}, out_damp_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdpa_en_r  <= 1'b0;
      iss_en_r   <= 1'b1;
      iss_gain_r <= RST_GAIN[COEF_W-1:0];
      iss_tau_r  <= RST_TAU[COEF_W-1:0];
      period_r   <= RST_PERIOD[COEF_W-1:0];
      rate_r     <= RST_RATE[COEF_W-1:0];
      vel_thr_r  <= RST_THR[COEF_W-1:0];
      out_damp_r <= RST_ODAMP[COEF_W-1:0];
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_TDPA_EN:  tdpa_en_r  <= pwdata[0];
        REG_ISS_EN:   iss_en_r   <= pwdata[0];
        REG_ISS_GAIN: iss_gain_r <= pwdata[COEF_W-1:0];
        REG_ISS_TAU:  iss_tau_r  <= pwdata[COEF_W-1:0];
        REG_PERIOD:   period_r   <= pwdata[COEF_W-1:0];
        REG_RATE:     rate_r     <= pwdata[COEF_W-1:0];
        REG_VEL_THR:  vel_thr_r  <= pwdata[COEF_W-1:0];
        REG_OUT_DAMP: out_damp_r <= pwdata[COEF_W-1:0];
        default:      ;
      endcase
    end
  end

  // ---------------- sequencer state ----------------
  state_t state_r;
  step_t  step_r;

  // per-request working values
  logic signed [DATA_W-1:0] v_r, f_r, erecv_r, pow_r, fout_r;
  logic                     fvalid_r;
  logic [COEF_W-1:0]        damp_r;

  // state carried between requests
  logic signed [DATA_W-1:0] ein_r, eout_r, ein_sent_r, prev_f_r, frate_r;

  // multiplier
  logic [DATA_W-1:0] mul_a_r, mul_b_r;
  logic              mul_neg_r;
  logic [ACC_W-1:0]  acc_r;
  logic [1:0]        mul_cnt_r;

  // divider
  logic [NUM_W-1:0]  div_num_r;
  logic [DATA_W-1:0] div_rem_r, div_d_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [1:0]        div_pass_r;

  // output register
  logic                     out_valid_r, out_fvalid_r;
  logic signed [DATA_W-1:0] out_vel_r, out_energy_r, out_force_r;
  logic [COEF_W-1:0]        out_damp_coef_r;

  logic in_acc, out_load;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_load  = (state_r == ST_DONE) & (~out_valid_r | out_tready);

  // ---------------- operand select ----------------
  logic signed [DATA_W:0] op_a, op_b;
  logic [DATA_W:0]        op_a_neg, op_b_neg;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      STP_VCORR: begin
        op_a = {frate_r[DATA_W-1], frate_r};
        op_b = {2'b00, iss_gain_r};
      end
      STP_POWER: begin
        op_a = {v_r[DATA_W-1], v_r};
        op_b = {f_r[DATA_W-1], f_r};
      end
      STP_ENERGY: begin
        op_a = {pow_r[DATA_W-1], pow_r};
        op_b = {2'b00, period_r};
      end
      STP_TDPA: begin
        op_a = {2'b00, damp_r};
        op_b = {v_r[DATA_W-1], v_r};
      end
      STP_RATE: begin
        // force difference is not clamped, it may need 49 bits
        op_a = {f_r[DATA_W-1], f_r} - {prev_f_r[DATA_W-1], prev_f_r};
        op_b = {2'b00, rate_r};
      end
      STP_TAU: begin
        op_a = {frate_r[DATA_W-1], frate_r};
        op_b = {2'b00, iss_tau_r};
      end
      STP_OUTD: begin
        op_a = {v_r[DATA_W-1], v_r};
        op_b = {2'b00, out_damp_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    op_a_neg = -op_a;
    op_b_neg = -op_b;
  end

  // ---------------- multiplier datapath ----------------
  logic [MUL_CHUNK_W-1:0]        mul_chunk;
  logic [DATA_W+MUL_CHUNK_W-1:0] mul_pp;
  logic [ACC_W-1:0]              mul_pp_sh;

  always_comb begin
    case (mul_cnt_r)
      2'd0: begin
        mul_chunk = mul_b_r[MUL_CHUNK_W-1:0];
      end
      2'd1: begin
        mul_chunk = mul_b_r[2*MUL_CHUNK_W-1:MUL_CHUNK_W];
      end
      default: begin
        mul_chunk = mul_b_r[3*MUL_CHUNK_W-1:2*MUL_CHUNK_W];
      end
    endcase
    mul_pp = mul_a_r * mul_chunk;
    case (mul_cnt_r)
      2'd0:    mul_pp_sh = {{(2*MUL_CHUNK_W){1'b0}}, mul_pp};
      2'd1:    mul_pp_sh = {{MUL_CHUNK_W{1'b0}}, mul_pp, {MUL_CHUNK_W{1'b0}}};
      default: mul_pp_sh = {mul_pp, {(2*MUL_CHUNK_W){1'b0}}};
    endcase
  end

  // rounded product: accumulator starts at half an LSB
  logic                     mul_big;
  logic [COEF_W-1:0]        mul_mag;
  logic signed [DATA_W-1:0] mres;

  always_comb begin
    mul_big = |acc_r[ACC_W-1:FRAC_BITS+COEF_W];
    mul_mag = acc_r[FRAC_BITS+COEF_W-1:FRAC_BITS];
    if (mul_big) begin
      mres = mul_neg_r ? Q_MIN : Q_MAX;
    end else if (mul_neg_r) begin
      mres = -{1'b0, mul_mag};
    end else begin
      mres = {1'b0, mul_mag};
    end
  end

  // write-back sums
  logic signed [DATA_W-1:0] v_plus_m, f_minus_v, f_minus_m, f_plus_m;
  logic signed [DATA_W-1:0] ein_plus_m, eout_minus_m, pow_new;

  always_comb begin
    v_plus_m     = sat48({v_r[DATA_W-1], v_r} + {mres[DATA_W-1], mres});
    f_minus_m    = sat48({f_r[DATA_W-1], f_r} - {mres[DATA_W-1], mres});
    f_minus_v    = f_minus_m;
    f_plus_m     = sat48({f_r[DATA_W-1], f_r} + {mres[DATA_W-1], mres});
    ein_plus_m   = sat48({ein_r[DATA_W-1], ein_r} + {mres[DATA_W-1], mres});
    eout_minus_m = sat48({eout_r[DATA_W-1], eout_r} - {mres[DATA_W-1], mres});
    pow_new      = (mres == Q_MIN) ? Q_MAX : -mres;
  end

  // ---------------- passivity check and divider ----------------
  logic [DATA_W-1:0]  vmag;
  logic [DATA_W:0]    ediff;
  logic               damp_cond;
  logic [DATA_W:0]    rem_sh, rem_sub;
  logic               div_ge;
  logic [DATA_W-1:0]  div_rem_nxt;
  logic [NUM_W-1:0]   div_num_nxt;
  logic [COEF_W-1:0]  div_q_sat;
  step_t              step_post_damp;

  always_comb begin
    vmag        = v_r[DATA_W-1] ? -v_r : v_r;
    ediff       = {eout_r[DATA_W-1], eout_r} - {erecv_r[DATA_W-1], erecv_r};
    damp_cond   = (eout_r > erecv_r) && (vmag > {1'b0, vel_thr_r});
    rem_sh      = {div_rem_r, div_num_r[NUM_W-1]};
    rem_sub     = rem_sh - {1'b0, div_d_r};
    div_ge      = (rem_sh >= {1'b0, div_d_r});
    div_rem_nxt = div_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    div_num_nxt = {div_num_r[NUM_W-2:0], div_ge};
    div_q_sat   = (|div_num_r[NUM_W-1:COEF_W]) ? COEF_MAX : div_num_r[COEF_W-1:0];
    if (tdpa_en_r) begin
      step_post_damp = STP_TDPA;
    end else if (iss_en_r) begin
      step_post_damp = STP_RATE;
    end else begin
      step_post_damp = STP_OUTD;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STP_VCORR;
      out_valid_r <= 1'b0;
      ein_r       <= '0;
      eout_r      <= '0;
      ein_sent_r  <= '0;
      prev_f_r    <= '0;
      frate_r     <= '0;
      mul_cnt_r   <= '0;
      div_cnt_r   <= '0;
      div_pass_r  <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            v_r      <= in_tdata[DATA_W-1:0];
            f_r      <= in_tdata[2*DATA_W-1:DATA_W];
            erecv_r  <= in_tdata[3*DATA_W-1:2*DATA_W];
            fvalid_r <= in_tuser[1];
            fout_r   <= '0;
            damp_r   <= '0;
            // energy to transmit is captured before this tick's update
            if (in_tuser[0]) begin
              ein_sent_r <= ein_r;
            end
            if (iss_en_r) begin
              step_r  <= STP_VCORR;
              state_r <= ST_ISSUE;
            end else if (in_tuser[1]) begin
              step_r  <= STP_POWER;
              state_r <= ST_ISSUE;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end

        ST_ISSUE: begin
          mul_a_r   <= op_a[DATA_W] ? op_a_neg[DATA_W-1:0] : op_a[DATA_W-1:0];
          mul_b_r   <= op_b[DATA_W] ? op_b_neg[DATA_W-1:0] : op_b[DATA_W-1:0];
          mul_neg_r <= op_a[DATA_W] ^ op_b[DATA_W];
          acc_r     <= ACC_W'(1) << (FRAC_BITS - 1);
          mul_cnt_r <= '0;
          state_r   <= ST_MUL;
        end

        ST_MUL: begin
          acc_r     <= acc_r + mul_pp_sh;
          mul_cnt_r <= mul_cnt_r + 2'd1;
          if (mul_cnt_r == 2'(MUL_STEPS - 1)) begin
            state_r <= ST_WB;
          end
        end

        ST_WB: begin
          case (step_r)
            STP_VCORR: begin
              v_r <= v_plus_m;
              if (fvalid_r) begin
                step_r  <= STP_POWER;
                state_r <= ST_ISSUE;
              end else begin
                state_r <= ST_DONE;
              end
            end
            STP_POWER: begin
              pow_r   <= pow_new;
              step_r  <= STP_ENERGY;
              state_r <= ST_ISSUE;
            end
            STP_ENERGY: begin
              if (!pow_r[DATA_W-1]) begin
                ein_r <= ein_plus_m;
              end else begin
                eout_r <= eout_minus_m;
              end
              state_r <= ST_CHECK;
            end
            STP_TDPA: begin
              f_r     <= f_minus_m;
              step_r  <= iss_en_r ? STP_RATE : STP_OUTD;
              state_r <= ST_ISSUE;
            end
            STP_RATE: begin
              frate_r  <= mres;
              prev_f_r <= f_r;
              step_r   <= STP_TAU;
              state_r  <= ST_ISSUE;
            end
            STP_TAU: begin
              f_r     <= f_plus_m;
              step_r  <= STP_OUTD;
              state_r <= ST_ISSUE;
            end
            STP_OUTD: begin
              fout_r  <= f_minus_v;
              state_r <= ST_DONE;
            end
            default: begin
              state_r <= ST_DONE;
            end
          endcase
        end

        ST_CHECK: begin
          step_r <= step_post_damp;
          if (damp_cond) begin
            eout_r <= erecv_r;
            if (period_r == '0) begin
              // zero period: coefficient pinned at full scale
              damp_r  <= COEF_MAX;
              state_r <= ST_ISSUE;
            end else begin
              // excess / T, then / |v| twice
              div_num_r  <= {ediff[DATA_W-1:0], {(3*FRAC_BITS){1'b0}}};
              div_rem_r  <= '0;
              div_d_r    <= {1'b0, period_r};
              div_cnt_r  <= '0;
              div_pass_r <= '0;
              state_r    <= ST_DIV;
            end
          end else begin
            state_r <= ST_ISSUE;
          end
        end

        ST_DIV: begin
          div_num_r <= div_num_nxt;
          if (div_cnt_r == DCNT_W'(NUM_W - 1)) begin
            div_cnt_r <= '0;
            div_rem_r <= '0;
            div_d_r   <= vmag;
            if (div_pass_r == 2'd2) begin
              state_r <= ST_DFIN;
            end else begin
              div_pass_r <= div_pass_r + 2'd1;
            end
          end else begin
            div_cnt_r <= div_cnt_r + DCNT_W'(1);
            div_rem_r <= div_rem_nxt;
          end
        end

        ST_DFIN: begin
          damp_r  <= div_q_sat;
          state_r <= ST_ISSUE;
        end

        ST_DONE: begin
          if (out_load) begin
            out_vel_r       <= v_r;
            out_energy_r    <= ein_sent_r;
            out_fvalid_r    <= fvalid_r;
            out_force_r     <= fout_r;
            out_damp_coef_r <= damp_r;
            state_r         <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fvalid_r;
  assign out_tdata  = {1'b0, out_damp_coef_r, out_force_r, out_energy_r, out_vel_r};

  // ---------------- assertions ----------------
  // a taken request keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while a previous one was accepted");

  // without a force message the force and damping fields are zero
  a_no_force_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[190:96] == '0)
    else $error("force or damping nonzero without force message");

  // the divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_d_r != '0)
    else $error("divide by zero in damping divider");

  // multiplier slice counter stays within its three slices
  a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> mul_cnt_r != 2'd3)
    else $error("multiplier slice counter out of range");

endmodule

/* verif/tb_passivity_controller_damping.sv */
// ----------------------------------------------------------------------------
// tb_passivity_controller_damping
// Self-checking bench for the z-axis passivity controller. Requests go in
// from a queue through a stream driver; every result is checked field by
// field against an in-bench fixed-point model of the controller. Runs a
// short directed set, then random phases under several register settings
// and back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_passivity_controller_damping;
  timeunit 1ns;
  timeprecision 1ps;

  import pcd_pkg::*;

  localparam int FRAC = 24;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_REQS = 200;

  // Q24.24 limits and register defaults, as plain 64-bit numbers
  localparam longint QMAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint QMIN   = -64'sh0000_8000_0000_0000;
  localparam longint MASK47 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ONE_Q  = 64'sd1 << FRAC;

  localparam longint DEF_GAIN   = 214542;
  localparam longint DEF_TAU    = 83886;
  localparam longint DEF_PERIOD = 16777;
  localparam longint DEF_RATE   = 64'sd16777216000;
  localparam longint DEF_VTHR   = 16777;
  localparam longint DEF_ODAMP  = 2516582;

  // one request: packed stream data plus the two flags
  typedef struct {
    logic [IN_TDATA_W-1:0] data;
    logic [IN_TUSER_W-1:0] user;
  } tick_req_t;

  // one result as bit patterns at the port widths
  typedef struct {
    logic [DATA_W-1:0] vel_out;
    logic [DATA_W-1:0] energy_out;
    logic              fout_valid;
    logic [DATA_W-1:0] fout;
    logic [COEF_W-1:0] damp;
  } tick_result_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  // velocity_z [47:0], force_z [95:48], received_energy [143:96]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // velocity_sent [0], force_valid [1]
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // velocity_out [47:0], energy_out [95:48], force_out [143:96],
  // damping [190:144], pad [191]
  logic [OUT_TDATA_W-1:0] out_tdata;
  // force_out_valid [0]
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_AW-1:0]      paddr = '0;
  logic [CFG_DW-1:0]      pwdata = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  passivity_controller_damping #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  tick_req_t    pending_reqs[$];     // requests not yet presented
  tick_result_t expected_ticks[$];   // predicted results, oldest first
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int           send_idle_pct = 20;  // chance per cycle the sender holds off
  int           recv_idle_pct = 84;  // chance per cycle out_tready is low
  bit           in_taken = 1'b0;     // request accepted at the last rising edge

  // Model copy of the register file (all non-negative)
  longint cfg_tdpa   = 0;
  longint cfg_iss    = 1;
  longint cfg_gain   = DEF_GAIN;
  longint cfg_tau    = DEF_TAU;
  longint cfg_period = DEF_PERIOD;
  longint cfg_rate   = DEF_RATE;
  longint cfg_vthr   = DEF_VTHR;
  longint cfg_odamp  = DEF_ODAMP;

  // Model copy of the controller state, all cleared by reset
  longint e_in       = 0;   // accumulated input energy
  longint e_out      = 0;   // accumulated output energy
  longint e_in_sent  = 0;   // input energy last transmitted
  longint f_prev     = 0;   // force at the last force-derivative update
  longint f_rate     = 0;   // force derivative

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------
  function automatic longint clamp48(input longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // exact product, >> FRAC with round half away from zero, then clamp.
  // a may be one bit wider than a Q word (force difference).
  function automatic longint q_mul(input longint a, input longint b);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    logic         neg;
    neg  = (a < 0) != (b < 0);
    ma   = magnitude(a);
    mb   = magnitude(b);
    prod = {64'd0, ma} * {64'd0, mb};
    prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
    if (neg) begin
      if (prod >= 128'h8000_0000_0000) return QMIN;
      return -longint'(prod[63:0]);
    end
    if (prod > 128'h7FFF_FFFF_FFFF) return QMAX;
    return longint'(prod[63:0]);
  endfunction

  // excess * 2^(3*FRAC) / (T * speed^2), truncated; saturates at 2^47-1.
  // Chained truncating divides equal one divide by the product.
  function automatic longint damping_coef(input longint excess, input longint speed);
    logic [191:0] num, den;
    if (cfg_period == 0) return MASK47;
    num = 192'(excess) << (3 * FRAC);
    den = 192'(cfg_period);
    den = den * 192'(speed);
    den = den * 192'(speed);
    num = num / den;
    if (num > 192'(MASK47)) return MASK47;
    return longint'(num[63:0]);
  endfunction

  // --------------------------------------------------------------------------
  // Controller model: one accepted request -> one result, state advanced
  // --------------------------------------------------------------------------
  task automatic controller_tick(input logic [IN_TDATA_W-1:0] d,
                                 input logic [IN_TUSER_W-1:0] u,
                                 output tick_result_t r);
    longint v, f, e_recv, pwr, de, f_cmd, damp;
    v      = longint'($signed(d[47:0]));
    f      = longint'($signed(d[95:48]));
    e_recv = longint'($signed(d[143:96]));
    f_cmd  = 0;
    damp   = 0;

    // velocity correction from the force derivative
    if (cfg_iss != 0) v = clamp48(v + q_mul(f_rate, cfg_gain));

    if (u[0]) e_in_sent = e_in;

    if (u[1]) begin
      // power flowing in is positive; it books to input, else output energy
      pwr = clamp48(-q_mul(v, f));
      de  = q_mul(pwr, cfg_period);
      if (pwr >= 0) e_in = clamp48(e_in + de);
      else e_out = clamp48(e_out - de);

      // passivity violated and moving fast enough: dissipate the excess
      if (e_out > e_recv && magnitude(v) > cfg_vthr) begin
        damp  = damping_coef(e_out - e_recv, magnitude(v));
        e_out = e_recv;
      end

      if (cfg_tdpa != 0) f = clamp48(f - q_mul(damp, v));

      if (cfg_iss != 0) begin
        // difference is not clamped before the multiply
        f_rate = q_mul(f - f_prev, cfg_rate);
        f_prev = f;
        f      = clamp48(f + q_mul(f_rate, cfg_tau));
      end

      f_cmd = clamp48(f - q_mul(v, cfg_odamp));
    end

    r.vel_out    = v[47:0];
    r.energy_out = e_in_sent[47:0];
    r.fout_valid = u[1];
    r.fout       = f_cmd[47:0];
    r.damp       = damp[46:0];
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic tick_req_t make_req(input longint v, input longint f,
                                         input longint e_recv, input bit sent,
                                         input bit fvalid);
    tick_req_t q;
    q.data = {e_recv[47:0], f[47:0], v[47:0]};
    q.user = {fvalid, sent};
    return q;
  endfunction

  // signed Q word: mostly physical magnitudes, some extremes and raw patterns
  function automatic longint rand_q();
    logic [47:0] raw;
    longint      m;
    int          sh;
    raw = 48'({$urandom(), $urandom()});
    case ($urandom_range(9))
      0: return QMIN;
      1: return QMAX;
      2, 3: return longint'($signed(raw));
      default: begin
        sh = $urandom_range(30, 4);
        m  = longint'(raw) & ((64'sd1 << sh) - 1);
        return $urandom_range(1) ? -m : m;
      end
    endcase
  endfunction

  // unsigned 47-bit register value
  function automatic longint rand_coef();
    logic [46:0] raw;
    raw = 47'({$urandom(), $urandom()});
    case ($urandom_range(5))
      0: return 0;
      1: return MASK47;
      2, 3: return longint'(raw) & ((64'sd1 << $urandom_range(26, 8)) - 1);
      default: return longint'(raw);
    endcase
  endfunction

  // APB write: setup then access cycle; pready is tied high
  task automatic cfg_write(input logic [2:0] idx, input longint val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_TDPA_EN:  cfg_tdpa   = val & 1;
      REG_ISS_EN:   cfg_iss    = val & 1;
      REG_ISS_GAIN: cfg_gain   = val & MASK47;
      REG_ISS_TAU:  cfg_tau    = val & MASK47;
      REG_PERIOD:   cfg_period = val & MASK47;
      REG_RATE:     cfg_rate   = val & MASK47;
      REG_VEL_THR:  cfg_vthr   = val & MASK47;
      REG_OUT_DAMP: cfg_odamp  = val & MASK47;
      default: ;
    endcase
  endtask

  task automatic set_config(input longint tdpa, input longint iss, input longint gain,
                            input longint tau, input longint period, input longint rate,
                            input longint vthr, input longint odamp);
    cfg_write(REG_TDPA_EN, tdpa);
    cfg_write(REG_ISS_EN, iss);
    cfg_write(REG_ISS_GAIN, gain);
    cfg_write(REG_ISS_TAU, tau);
    cfg_write(REG_PERIOD, period);
    cfg_write(REG_RATE, rate);
    cfg_write(REG_VEL_THR, vthr);
    cfg_write(REG_OUT_DAMP, odamp);
  endtask

  // wait until every queued request went in and every result came back;
  // a short settle keeps register writes clear of the sequencer
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_ticks.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: presents queued requests on the falling edge, with
  // random hold-off. A new request replaces one accepted at the last edge.
  // The result side's ready is randomized here too.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= pending_reqs[0].data;
        in_tuser  <= pending_reqs[0].user;
        in_tvalid <= 1'b1;
        void'(pending_reqs.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    tick_result_t pred, want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      controller_tick(in_tdata, in_tuser, pred);
      expected_ticks.push_back(pred);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_ticks.size() == 0) begin
        $error("unexpected result: tdata %h tuser %h", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("velocity_out", 64'(want.vel_out), 64'(out_tdata[47:0]));
        check_field("energy_out", 64'(want.energy_out), 64'(out_tdata[95:48]));
        check_field("force_out_valid", 64'(want.fout_valid), 64'(out_tuser[0]));
        check_field("force_out", 64'(want.fout), 64'(out_tdata[143:96]));
        check_field("damping", 64'(want.damp), 64'(out_tdata[190:144]));
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed: field extremes, energy routing, damping boundaries ----
    cfg_write(REG_TDPA_EN, 1);
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0));                 // idle tick
    pending_reqs.push_back(make_req(QMAX, QMAX, QMIN, 1, 1));
    pending_reqs.push_back(make_req(QMIN, QMIN, QMAX, 1, 1));
    pending_reqs.push_back(make_req(QMAX, QMIN, 0, 0, 1));           // power in
    pending_reqs.push_back(make_req(QMIN, QMAX, 0, 1, 1));
    pending_reqs.push_back(make_req(ONE_Q, 2 * ONE_Q, -(64'sd1 << 30), 0, 1));
    pending_reqs.push_back(make_req(ONE_Q, 2 * ONE_Q, QMAX, 0, 1));  // no violation
    pending_reqs.push_back(make_req(100, ONE_Q, QMIN, 0, 1));        // too slow
    pending_reqs.push_back(make_req(DEF_VTHR, ONE_Q, QMIN, 1, 1));   // at threshold
    pending_reqs.push_back(make_req(DEF_VTHR + 1, ONE_Q, QMIN, 0, 1));
    pending_reqs.push_back(make_req(ONE_Q, 5 * ONE_Q, QMIN, 1, 0));  // no force message
    pending_reqs.push_back(make_req(-(64'sd1 << 20), -(64'sd1 << 26), QMIN, 1, 1));
    pending_reqs.push_back(make_req(1, -1, -1, 1, 1));
    pending_reqs.push_back(make_req(-1, -1, -1, 0, 1));
    pending_reqs.push_back(make_req(64'sh5555_5555_5555, -64'sh5555_5555_5556,
                                    64'sh5555_5555_5555, 1, 1));
    pending_reqs.push_back(make_req(-64'sh5555_5555_5556, 64'sh5555_5555_5555,
                                    -64'sh5555_5555_5556, 0, 1));
    drain();

    // zero integration step while damping is due: coefficient saturates
    cfg_write(REG_PERIOD, 0);
    pending_reqs.push_back(make_req(ONE_Q, ONE_Q, QMIN, 0, 1));
    pending_reqs.push_back(make_req(QMIN, QMIN, QMIN, 1, 1));
    pending_reqs.push_back(make_req(-ONE_Q, ONE_Q, -ONE_Q, 0, 1));
    drain();

    // ---- random phases: settings change only while the block is idle ----
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 84;
      end else if (ph < 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_config(1, 1, DEF_GAIN, DEF_TAU, DEF_PERIOD, DEF_RATE, DEF_VTHR, DEF_ODAMP);
        1: set_config(1, 1, MASK47, MASK47, MASK47, MASK47, MASK47, MASK47);
        2: set_config(0, 0, 0, 0, 0, 0, 0, 0);
        default: set_config(longint'($urandom_range(1)), longint'($urandom_range(1)),
                            rand_coef(), rand_coef(),
                            rand_coef(), rand_coef(), rand_coef(), rand_coef());
      endcase
      // mostly force messages, half the ticks transmit the velocity
      for (int i = 0; i < PHASE_REQS; i++)
        pending_reqs.push_back(make_req(rand_q(), rand_q(), rand_q(),
                                        1'($urandom_range(1)), $urandom_range(3) != 0));
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
